FILE: src/double_ended_queue_macros.svh
// Assertion macros shared by the queue RTL.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

`ifndef SYNTH
`define DQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define DQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DQ_ASSERT_NOW(lbl, ante, cons, msg)
`define DQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: src/dq_pkg.sv
`timescale 1ns / 1ps

package dq_pkg;

    localparam int REQ_W   = 3;
    localparam int IDX_W   = 4;
    localparam int ST_W    = 2;
    localparam int CNT_W   = 5;
    localparam int OUT_W   = 32;
    localparam int IN_W    = 32;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_READ       = 3'd4;
    localparam logic [REQ_W-1:0] REQ_REMOVE     = 3'd5;

    // Status codes.
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

endpackage

FILE: src/dq_ram.sv
`timescale 1ns / 1ps

module dq_ram #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         we,
    input  logic [$clog2(DEPTH)-1:0]     waddr,
    input  logic [DATA_WIDTH-1:0]        wdata,
    input  logic [$clog2(DEPTH)-1:0]     raddr,
    output logic [DATA_WIDTH-1:0]        rdata
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read data is registered and returns in the cycle after the address; a write in the same cycle is not seen.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

FILE: src/double_ended_queue.sv
`timescale 1ns / 1ps
// Channel   Handshake           Payload
// request   start / busy        req_type, value, index
// result    done (one cycle)    status, read_value, front_value, back_value, count
//
// A request is taken when start is high and busy is low; done pulses in the cycle after
// the last busy cycle, and a new request may be taken in that same cycle.
// A remove moves each element behind the removed one a place forward, one element per
// cycle, through the single read and write port of the storage memory. The front and back
// words are read back from memory after every request, and that read-back is skipped when
// the queue is empty after the request.
// Reset empties the queue at once; storage contents are not cleared.
// The result port cannot stall: done is high for exactly one cycle, and the result values hold until the next request.

module double_ended_queue
    import dq_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [REQ_W-1:0]  req_type,
    input  logic [IN_W-1:0]   value,
    input  logic [IDX_W-1:0]  index,
    output logic              done,
    output logic [ST_W-1:0]   status,
    output logic [OUT_W-1:0]  read_value,
    output logic [OUT_W-1:0]  front_value,
    output logic [OUT_W-1:0]  back_value,
    output logic [CNT_W-1:0]  count
);

`include "double_ended_queue_macros.svh"

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > IDX_W) ? CW : IDX_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_OP     = 3'd1;
    localparam logic [2:0] S_RDWAIT = 3'd2;
    localparam logic [2:0] S_SHIFT  = 3'd3;
    localparam logic [2:0] S_FRONT  = 3'd4;
    localparam logic [2:0] S_BACK   = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0]            state_reg, state_next;
    logic [REQ_W-1:0]      req_reg, req_next;
    logic [DATA_WIDTH-1:0] val_reg, val_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [PW-1:0]         front_reg, front_next;
    logic [CW-1:0]         fill_reg, fill_next;
    logic [CW-1:0]         sh_off_reg, sh_off_next;
    logic                  done_reg, done_next;
    logic [ST_W-1:0]       status_reg, status_next;
    logic [OUT_W-1:0]      read_value_reg, read_value_next;
    logic [OUT_W-1:0]      front_value_reg, front_value_next;
    logic [OUT_W-1:0]      back_value_reg, back_value_next;
    logic [CNT_W-1:0]      count_reg, count_next;

    logic                  mem_we;
    logic [PW-1:0]         mem_waddr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic [PW-1:0]         mem_raddr;
    logic [DATA_WIDTH-1:0] mem_rdata;

    logic [ST_W-1:0]       status_now;
    logic                  op_ok;
    logic                  is_full;
    logic                  q_empty;
    logic                  idx_bad;
    logic [CW-1:0]         fill_m1;
    logic [CW-1:0]         idx_off;
    logic [PW-1:0]         front_dec;
    logic [63:0]           value_wide;

    // Ring position of the element at offset off from base; off stays below DEPTH.
    function automatic logic [PW-1:0] ring_pos(input logic [PW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [CW:0] s;
        s = (CW+1)'(base) + (CW+1)'(off);
        if (s >= (CW+1)'(DEPTH))
        begin
            s = s - (CW+1)'(DEPTH);
        end
        return s[PW-1:0];
    endfunction

    function automatic logic [OUT_W-1:0] to_out(input logic [DATA_WIDTH-1:0] d);
        logic [63:0] w;
        w = 64'(d);
        return w[OUT_W-1:0];
    endfunction

    dq_ram #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign value_wide = 64'(value);
    assign is_full    = (fill_reg == CW'(DEPTH));
    assign q_empty    = (fill_reg == '0);
    assign idx_bad    = (XW'(idx_reg) >= XW'(fill_reg));
    assign fill_m1    = fill_reg - CW'(1);
    assign idx_off    = CW'(idx_reg);
    assign front_dec  = (front_reg == '0) ? PW'(DEPTH - 1) : front_reg - PW'(1);

    always_comb
    begin
        status_now = ST_OK;
        op_ok      = 1'b0;
        case (req_reg)
            REQ_PUSH_FRONT, REQ_PUSH_BACK:
            begin
                status_now = is_full ? ST_FULL : ST_OK;
                op_ok      = !is_full;
            end
            REQ_POP_FRONT, REQ_POP_BACK:
            begin
                status_now = q_empty ? ST_EMPTY : ST_OK;
                op_ok      = !q_empty;
            end
            REQ_READ, REQ_REMOVE:
            begin
                status_now = q_empty ? ST_EMPTY : (idx_bad ? ST_RANGE : ST_OK);
                op_ok      = !q_empty && !idx_bad;
            end
            default:
            begin
                status_now = ST_OK;
                op_ok      = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next       = state_reg;
        req_next         = req_reg;
        val_next         = val_reg;
        idx_next         = idx_reg;
        front_next       = front_reg;
        fill_next        = fill_reg;
        sh_off_next      = sh_off_reg;
        done_next        = 1'b0;
        status_next      = status_reg;
        read_value_next  = read_value_reg;
        front_value_next = front_value_reg;
        back_value_next  = back_value_reg;
        count_next       = count_reg;
        mem_we           = 1'b0;
        mem_waddr        = '0;
        mem_wdata        = val_reg;
        mem_raddr        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next        = req_type;
                    val_next        = value_wide[DATA_WIDTH-1:0];
                    idx_next        = index;
                    read_value_next = '0;
                    state_next      = S_OP;
                end
            end
            S_OP:
            begin
                status_next = status_now;
                state_next  = S_FRONT;
                if (op_ok)
                begin
                    case (req_reg)
                        REQ_PUSH_FRONT:
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = front_dec;
                            front_next = front_dec;
                            fill_next  = fill_reg + CW'(1);
                        end
                        REQ_PUSH_BACK:
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = ring_pos(front_reg, fill_reg);
                            fill_next = fill_reg + CW'(1);
                        end
                        REQ_POP_FRONT:
                        begin
                            mem_raddr  = ring_pos(front_reg, '0);
                            state_next = S_RDWAIT;
                        end
                        REQ_POP_BACK:
                        begin
                            mem_raddr  = ring_pos(front_reg, fill_m1);
                            state_next = S_RDWAIT;
                        end
                        REQ_READ, REQ_REMOVE:
                        begin
                            mem_raddr   = ring_pos(front_reg, idx_off);
                            sh_off_next = idx_off;
                            state_next  = S_RDWAIT;
                        end
                        default:
                        begin
                            state_next = S_FRONT;
                        end
                    endcase
                end
            end
            S_RDWAIT:
            begin
                read_value_next = to_out(mem_rdata);
                state_next      = S_FRONT;
                case (req_reg)
                    REQ_POP_FRONT:
                    begin
                        front_next = ring_pos(front_reg, CW'(1));
                        fill_next  = fill_m1;
                    end
                    REQ_POP_BACK:
                    begin
                        fill_next = fill_m1;
                    end
                    REQ_REMOVE:
                    begin
                        // Later elements exist: start moving them one place forward.
                        if ((CW+1)'(sh_off_reg) + (CW+1)'(1) < (CW+1)'(fill_reg))
                        begin
                            mem_raddr  = ring_pos(front_reg, sh_off_reg + CW'(1));
                            state_next = S_SHIFT;
                        end
                        else
                        begin
                            fill_next = fill_m1;
                        end
                    end
                    default:
                    begin
                        state_next = S_FRONT;
                    end
                endcase
            end
            S_SHIFT:
            begin
                // Read data holds the element behind sh_off; the next read runs two ahead
                // of the write, so the two never touch the same entry.
                mem_we    = 1'b1;
                mem_waddr = ring_pos(front_reg, sh_off_reg);
                mem_wdata = mem_rdata;
                if ((CW+1)'(sh_off_reg) + (CW+1)'(2) < (CW+1)'(fill_reg))
                begin
                    mem_raddr   = ring_pos(front_reg, sh_off_reg + CW'(2));
                    sh_off_next = sh_off_reg + CW'(1);
                end
                else
                begin
                    fill_next  = fill_m1;
                    state_next = S_FRONT;
                end
            end
            S_FRONT:
            begin
                if (q_empty)
                begin
                    front_value_next = '0;
                    back_value_next  = '0;
                    count_next       = CNT_W'(fill_reg);
                    done_next        = 1'b1;
                    state_next       = S_IDLE;
                end
                else
                begin
                    mem_raddr  = ring_pos(front_reg, '0);
                    state_next = S_BACK;
                end
            end
            S_BACK:
            begin
                mem_raddr        = ring_pos(front_reg, fill_m1);
                front_value_next = to_out(mem_rdata);
                state_next       = S_DONE;
            end
            S_DONE:
            begin
                back_value_next = to_out(mem_rdata);
                count_next      = CNT_W'(fill_reg);
                done_next       = 1'b1;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            front_reg  <= '0;
            fill_reg   <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            front_reg  <= front_next;
            fill_reg   <= fill_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg         <= req_next;
        val_reg         <= val_next;
        idx_reg         <= idx_next;
        sh_off_reg      <= sh_off_next;
        status_reg      <= status_next;
        read_value_reg  <= read_value_next;
        front_value_reg <= front_value_next;
        back_value_reg  <= back_value_next;
        count_reg       <= count_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign read_value  = read_value_reg;
    assign front_value = front_value_reg;
    assign back_value  = back_value_reg;
    assign count       = count_reg;

    `DQ_ASSERT_NOW(a_done_idle, done, !busy, "result strobe while a request is in progress")
    `DQ_ASSERT_NEXT(a_start_busy, start && !busy, busy && !done, "accepted request did not start")
    `DQ_ASSERT_NOW(a_full_count, done && (status == ST_FULL),
        count == CNT_W'(DEPTH), "full status with room left")
    `DQ_ASSERT_NOW(a_empty_zero, done && (status == ST_EMPTY),
        (count == '0) && (front_value == '0) && (back_value == '0),
        "empty status on a non-empty queue")
    `DQ_ASSERT_NOW(a_fill_bound, busy, fill_reg <= CW'(DEPTH), "element count beyond depth")

endmodule
